// ===== hw/rtl/kli_pkg.sv =====
// Shared types and constants for the keyframe linear interpolator.
`timescale 1ns / 1ps
package kli_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned NumCmp = 6;
  localparam int unsigned EntryW = DataW * (NumCmp + 1);
  localparam int unsigned LamW   = 17;
  localparam int unsigned AccW   = DataW + 1 + LamW;
  localparam int unsigned FracW  = 16;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_TRANS_X = 3'd0,
    CFG_TRANS_Y = 3'd1,
    CFG_TRANS_Z = 3'd2,
    CFG_ROT_X   = 3'd3,
    CFG_ROT_Y   = 3'd4,
    CFG_ROT_Z   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_TO,
    ST_CHK,
    ST_RD_FROM,
    ST_LD_FROM,
    ST_LD_TO,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
    logic lam_bit;
  } lerp_ctl_t;

endpackage

// ===== hw/rtl/kli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/kli_lerp.sv =====
// One interpolated component: bit-serial multiply of weight by span, then floor and add.
`timescale 1ns / 1ps
module kli_lerp
  import kli_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lerp_ctl_t        ctl_i,
  input  logic [DataW-1:0] data_i,
  input  logic [DataW-1:0] base_i,
  output logic [DataW-1:0] res_o
);

  logic [DataW-1:0]  a_q, a_d;
  logic [DataW:0]    diff_q, diff_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]   addend;

  always_comb begin
    a_d    = a_q;
    diff_d = diff_q;
    acc_d  = acc_q;
    addend = ctl_i.lam_bit ? {{(AccW-DataW-1){diff_q[DataW]}}, diff_q} : '0;
    if (ctl_i.load_a) begin
      a_d = data_i;
    end
    if (ctl_i.load_b) begin
      diff_d = {data_i[DataW-1], data_i} - {a_q[DataW-1], a_q};
      acc_d  = '0;
    end else if (ctl_i.step) begin
      acc_d = {acc_q[AccW-2:0], 1'b0} + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    diff_q <= diff_d;
  end

  assign res_o = a_q + acc_q[FracW+DataW-1:FracW] + base_i;

endmodule

// ===== hw/rtl/keyframe_linear_interpolator.sv =====
// Top level of the looping linear keyframe interpolator.
// Append and restart complete in the idle state and leave busy low.
// A tick with keys holds busy through read, check and load states, 16 divide steps,
// 17 multiply steps and an output state. A saturated or zero weight skips the divide.
// The strobe follows the last busy cycle; a new item is accepted from the strobe cycle on.
// Reset clears the key count, segment index, time offset and base pose; no clearing pass.
`timescale 1ns / 1ps
module keyframe_linear_interpolator
  import kli_pkg::*;
#(
  parameter int unsigned MAX_KEYFRAMES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] key_time_i,
  input  logic [31:0] key_pos_x_i,
  input  logic [31:0] key_pos_y_i,
  input  logic [31:0] key_pos_z_i,
  input  logic [31:0] key_rot_x_i,
  input  logic [31:0] key_rot_y_i,
  input  logic [31:0] key_rot_z_i,
  input  logic [31:0] now_time_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [31:0] out_trans_x_o,
  output logic [31:0] out_trans_y_o,
  output logic [31:0] out_trans_z_o,
  output logic [31:0] out_rot_x_o,
  output logic [31:0] out_rot_y_o,
  output logic [31:0] out_rot_z_o,
  output logic [3:0]  segment_start_o
);

  localparam int unsigned AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYFRAMES + 1);

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      seg_q, seg_d;
  logic [AW-1:0]      from_q, from_d;
  logic [AW-1:0]      to_q, to_d;
  logic [DataW-1:0]   offset_q, offset_d;
  logic [DataW-1:0]   now_q, now_d;
  logic [DataW-1:0]   elapsed_q, elapsed_d;
  logic [DataW-1:0]   tf_q, tf_d;
  logic [DataW:0]     span_q, span_d;
  logic [DataW:0]     rem_q, rem_d;
  logic [LamW-1:0]    lam_q, lam_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               valid_q, valid_d;
  logic [DataW-1:0]   base_q [NumCmp];
  logic [DataW-1:0]   res_q [NumCmp];
  logic [DataW-1:0]   res_w [NumCmp];
  logic [3:0]         segout_q;

  logic               accept;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [EntryW-1:0]  ram_wdata;
  logic [EntryW-1:0]  ram_rdata;
  logic [DataW-1:0]   rd_time;
  lerp_ctl_t          ctl;
  logic [AW-1:0]      next_of_seg;
  logic [AW-1:0]      next_of_to;
  logic [CW-1:0]      inc_seg;
  logic [CW-1:0]      inc_to;
  logic [DataW:0]     span_w;
  logic [DataW:0]     num_w;
  logic [DataW+1:0]   rem2;
  logic [DataW+1:0]   rem_sub;
  logic [31:0]        seg_ext;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rd_time     = ram_rdata[EntryW-1 -: DataW];

  assign inc_seg     = CW'(seg_q) + CW'(1);
  assign next_of_seg = (inc_seg == count_q) ? '0 : inc_seg[AW-1:0];
  assign inc_to      = CW'(to_q) + CW'(1);
  assign next_of_to  = (inc_to == count_q) ? '0 : inc_to[AW-1:0];

  assign ram_we    = accept && (req_e'(req_type_i) == REQ_APPEND) &&
                     (count_q < CW'(MAX_KEYFRAMES));
  assign ram_wdata = {key_time_i, key_rot_z_i, key_rot_y_i, key_rot_x_i,
                      key_pos_z_i, key_pos_y_i, key_pos_x_i};

  assign span_w  = {1'b0, rd_time} - {1'b0, tf_q};
  assign num_w   = {1'b0, elapsed_q} - {1'b0, tf_q};
  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, span_q};

  kli_ram #(
    .Width (EntryW),
    .Depth (MAX_KEYFRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  for (genvar c = 0; c < NumCmp; c++) begin : g_lerp
    kli_lerp u_lerp (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .data_i (ram_rdata[c*DataW +: DataW]),
      .base_i (base_q[c]),
      .res_o  (res_w[c])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    seg_d     = seg_q;
    from_d    = from_q;
    to_d      = to_q;
    offset_d  = offset_q;
    now_d     = now_q;
    elapsed_d = elapsed_q;
    tf_d      = tf_q;
    span_d    = span_q;
    rem_d     = rem_q;
    lam_d     = lam_q;
    cnt_d     = cnt_q;
    valid_d   = 1'b0;
    ram_raddr = to_q;
    ctl       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_e'(req_type_i))
            REQ_APPEND: begin
              if (ram_we) begin
                count_d = count_q + CW'(1);
              end
            end
            REQ_RESTART: begin
              seg_d    = '0;
              offset_d = now_time_i;
            end
            REQ_TICK: begin
              if (count_q != '0) begin
                from_d  = seg_q;
                to_d    = next_of_seg;
                now_d   = now_time_i;
                state_d = ST_RD_TO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_TO: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        elapsed_d = now_q - offset_q;
        seg_d     = from_q;
        if ((now_q - offset_q) > rd_time) begin
          from_d = to_q;
          to_d   = next_of_to;
          seg_d  = to_q;
          if (to_q == '0) begin
            offset_d  = now_q;
            elapsed_d = '0;
          end
        end
        state_d = ST_RD_FROM;
      end
      ST_RD_FROM: begin
        ram_raddr = from_q;
        state_d   = ST_LD_FROM;
      end
      ST_LD_FROM: begin
        ctl.load_a = 1'b1;
        tf_d       = rd_time;
        state_d    = ST_LD_TO;
      end
      ST_LD_TO: begin
        ctl.load_b = 1'b1;
        span_d     = span_w;
        rem_d      = num_w;
        cnt_d      = '0;
        if (span_w[DataW] || (span_w == '0) ||
            (!num_w[DataW] && (num_w >= span_w))) begin
          lam_d   = LamW'(1) << FracW;
          state_d = ST_MUL;
        end else if (num_w[DataW] || (num_w == '0)) begin
          lam_d   = '0;
          state_d = ST_MUL;
        end else begin
          lam_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!rem_sub[DataW+1]) begin
          rem_d = rem_sub[DataW:0];
          lam_d = {lam_q[LamW-2:0], 1'b1};
        end else begin
          rem_d = rem2[DataW:0];
          lam_d = {lam_q[LamW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(FracW - 1)) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.step    = 1'b1;
        ctl.lam_bit = lam_q[LamW-1];
        lam_d       = {lam_q[LamW-2:0], 1'b0};
        cnt_d       = cnt_q + 5'd1;
        if (cnt_q == 5'(LamW - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      seg_q    <= '0;
      offset_q <= '0;
      valid_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      seg_q    <= seg_d;
      offset_q <= offset_d;
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCmp; i++) begin
        base_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TRANS_X: base_q[0] <= cfg_data_i;
        CFG_TRANS_Y: base_q[1] <= cfg_data_i;
        CFG_TRANS_Z: base_q[2] <= cfg_data_i;
        CFG_ROT_X:   base_q[3] <= cfg_data_i;
        CFG_ROT_Y:   base_q[4] <= cfg_data_i;
        CFG_ROT_Z:   base_q[5] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign seg_ext = 32'(from_q);

  always_ff @(posedge clk_i) begin
    from_q    <= from_d;
    to_q      <= to_d;
    now_q     <= now_d;
    elapsed_q <= elapsed_d;
    tf_q      <= tf_d;
    span_q    <= span_d;
    rem_q     <= rem_d;
    lam_q     <= lam_d;
    if (state_q == ST_OUT) begin
      for (int i = 0; i < NumCmp; i++) begin
        res_q[i] <= res_w[i];
      end
      segout_q <= seg_ext[3:0];
    end
  end

  assign result_valid_o  = valid_q;
  assign out_trans_x_o   = res_q[0];
  assign out_trans_y_o   = res_q[1];
  assign out_trans_z_o   = res_q[2];
  assign out_rot_x_o     = res_q[3];
  assign out_rot_y_o     = res_q[4];
  assign out_rot_z_o     = res_q[5];
  assign segment_start_o = segout_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held longer than one cycle");

  a_strobe_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q) == ST_OUT)
    else $error("result strobe without finished tick");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CW'(seg_q) < count_q))
    else $error("segment index beyond key count");

  a_busy_needs_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (count_q != '0))
    else $error("tick in work with empty table");

  a_lam_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MUL) && (cnt_q == '0)) |-> (lam_q <= (LamW'(1) << FracW)))
    else $error("weight above one");

endmodule
